@@ src/lrutc_pkg.sv @@
// Shared constants and types for the LRU cache tag controller.
// No dependencies; compile first.
package lrutc_pkg;

  localparam int WAYS           = 4;
  localparam int SET_INDEX_BITS = 4;
  localparam int OFFSET_BITS    = 6;
  localparam int ADDRESS_BITS   = 20;

  localparam int SET_COUNT = 1 << SET_INDEX_BITS;
  localparam int TAG_BITS  = ADDRESS_BITS - SET_INDEX_BITS - OFFSET_BITS;
  localparam int LINE_BITS = ADDRESS_BITS - OFFSET_BITS;
  localparam int WAY_BITS  = $clog2(WAYS);
  localparam int AGE_BITS  = $clog2(WAYS);

  localparam logic [AGE_BITS-1:0] AGE_OLDEST = AGE_BITS'(WAYS - 1);
  localparam logic [WAY_BITS-1:0] WAY_LAST   = WAY_BITS'(WAYS - 1);

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // One memory row holds the whole set.
  typedef struct packed {
    logic [WAYS-1:0]                valid;
    logic [WAYS-1:0]                dirty;
    logic [WAYS-1:0][TAG_BITS-1:0]  tag;
    logic [WAYS-1:0][AGE_BITS-1:0]  age;
  } set_row_t;

  localparam int ROW_BITS = $bits(set_row_t);

  typedef struct packed {
    logic                hit;
    logic [WAY_BITS-1:0] way;
    logic                writeback;
    logic [TAG_BITS-1:0] wb_tag;
    logic                fill;
  } lookup_res_t;

endpackage

@@ src/lrutc_if.sv @@
// Request and response channel interfaces (valid/ready).
// Depends on lrutc_pkg.
interface lrutc_req_if;
  import lrutc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [ADDRESS_BITS-1:0] address;

  modport source (output valid, req_type, address, input ready);
  modport sink   (input valid, req_type, address, output ready);
endinterface

interface lrutc_rsp_if;
  import lrutc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [WAY_BITS-1:0]  way;
  logic                 writeback;
  logic [LINE_BITS-1:0] writeback_line;
  logic                 fill;
  logic [LINE_BITS-1:0] fill_line;

  modport source (output valid, hit, way, writeback, writeback_line, fill, fill_line,
                  input ready);
  modport sink   (input valid, hit, way, writeback, writeback_line, fill, fill_line,
                  output ready);
endinterface

@@ src/lrutc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lrutc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ src/lrutc_lru_update.sv @@
// Tag compare, victim choice and LRU age update for one set row.
// Depends on lrutc_pkg.
module lrutc_lru_update (
  input  lrutc_pkg::set_row_t              row_i,
  input  logic [lrutc_pkg::TAG_BITS-1:0]   tag_i,
  input  logic                             req_type_i,
  output lrutc_pkg::set_row_t              row_o,
  output lrutc_pkg::lookup_res_t           res_o
);
  import lrutc_pkg::*;

  logic                hit;
  logic [WAY_BITS-1:0] hit_way;
  logic [WAY_BITS-1:0] victim;
  logic [WAY_BITS-1:0] sel;
  logic [AGE_BITS-1:0] old_age;

  function automatic logic [AGE_BITS-1:0] age_up(input logic [AGE_BITS-1:0] a);
    return (a < AGE_OLDEST) ? a + AGE_BITS'(1) : a;
  endfunction

  // Lowest-numbered match wins.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_i.valid[w] && row_i.tag[w] == tag_i) begin
        hit     = 1'b1;
        hit_way = WAY_BITS'(w);
      end
    end
  end

  // Highest-numbered invalid or oldest way.
  always_comb begin
    victim = WAY_LAST;
    for (int w = 0; w < WAYS; w++) begin
      if (!row_i.valid[w] || row_i.age[w] == AGE_OLDEST) begin
        victim = WAY_BITS'(w);
      end
    end
  end

  assign sel     = hit ? hit_way : victim;
  assign old_age = row_i.age[sel];

  always_comb begin
    row_o = row_i;
    if (hit || row_i.valid[sel]) begin
      // Ways younger than the selected one move up by one.
      for (int w = 0; w < WAYS; w++) begin
        if (WAY_BITS'(w) != sel && (hit ? row_i.valid[w] : 1'b1) &&
            row_i.age[w] < old_age) begin
          row_o.age[w] = age_up(row_i.age[w]);
        end
      end
    end else begin
      // Fill into an empty way: every valid way ages.
      for (int w = 0; w < WAYS; w++) begin
        if (row_i.valid[w]) begin
          row_o.age[w] = age_up(row_i.age[w]);
        end
      end
    end
    row_o.age[sel] = '0;
    if (!hit) begin
      row_o.valid[sel] = 1'b1;
      row_o.dirty[sel] = 1'b0;
      row_o.tag[sel]   = tag_i;
    end
    if (req_type_i == REQ_WRITE) begin
      row_o.dirty[sel] = 1'b1;
    end
  end

  always_comb begin
    res_o.hit       = hit;
    res_o.way       = sel;
    res_o.writeback = !hit && row_i.valid[sel] && row_i.dirty[sel];
    res_o.wb_tag    = row_i.tag[sel];
    res_o.fill      = !hit;
  end

endmodule

@@ src/lru_cache_tag_controller.sv @@
// 4-way, 16-set write-back cache tag controller with true LRU ages.
// The set is read at request accept; the lookup result and the set update are registered
// in ST_LOOKUP, which waits until the response register is free or draining.
// A new request is taken only in ST_IDLE, once the read-modify-write of the set RAM is done.
// Reset: asynchronous, active low; every set reads as empty through per-set init bits,
// so no clearing pass is needed and requests are taken right after reset.
// Depends on lrutc_pkg, lrutc_if, lrutc_ram, lrutc_lru_update.
module lru_cache_tag_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  lrutc_req_if.sink   req_i,
  lrutc_rsp_if.source rsp_o
);
  import lrutc_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q, state_d;

  // Request captured at accept time
  logic [SET_INDEX_BITS-1:0] set_q;
  logic [TAG_BITS-1:0]       tag_q;
  logic [LINE_BITS-1:0]      line_q;
  logic                      req_type_q;

  // Per-set init bits: a set never written reads as all-invalid, zero ages.
  logic [SET_COUNT-1:0] row_init_q;

  // Response register
  logic                 rsp_valid_q;
  logic                 rsp_hit_q;
  logic [WAY_BITS-1:0]  rsp_way_q;
  logic                 rsp_wb_q;
  logic [LINE_BITS-1:0] rsp_wb_line_q;
  logic                 rsp_fill_q;
  logic [LINE_BITS-1:0] rsp_fill_line_q;

  logic                      req_take;
  logic                      done;
  logic [SET_INDEX_BITS-1:0] req_set;
  logic [ROW_BITS-1:0]       rd_data;
  set_row_t                  row_cur;
  set_row_t                  row_next;
  lookup_res_t               res;

  assign req_set  = req_i.address[OFFSET_BITS +: SET_INDEX_BITS];
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_take = req_i.valid && req_i.ready;

  // Finish the lookup once the response register is free or draining.
  assign done = (state_q == ST_LOOKUP) && (!rsp_valid_q || rsp_o.ready);

  lrutc_ram #(
    .WIDTH(ROW_BITS),
    .DEPTH(SET_COUNT)
  ) u_set_ram (
    .clk_i  (clk_i),
    .we_i   (done),
    .waddr_i(set_q),
    .wdata_i(row_next),
    .re_i   (req_take),
    .raddr_i(req_set),
    .rdata_o(rd_data)
  );

  // Read data stays put while a lookup waits on the response side.
  assign row_cur = row_init_q[set_q] ? set_row_t'(rd_data) : '0;

  lrutc_lru_update u_update (
    .row_i     (row_cur),
    .tag_i     (tag_q),
    .req_type_i(req_type_q),
    .row_o     (row_next),
    .res_o     (res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_take) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
      row_init_q  <= '0;
    end else begin
      state_q <= state_d;
      if (req_take) begin
        set_q      <= req_set;
        tag_q      <= req_i.address[OFFSET_BITS + SET_INDEX_BITS +: TAG_BITS];
        line_q     <= req_i.address[OFFSET_BITS +: LINE_BITS];
        req_type_q <= req_i.req_type;
      end
      if (done) begin
        row_init_q[set_q] <= 1'b1;
        rsp_valid_q       <= 1'b1;
        rsp_hit_q         <= res.hit;
        rsp_way_q         <= res.way;
        rsp_wb_q          <= res.writeback;
        rsp_wb_line_q     <= res.writeback ? {res.wb_tag, set_q} : '0;
        rsp_fill_q        <= res.fill;
        rsp_fill_line_q   <= res.fill ? line_q : '0;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.hit            = rsp_hit_q;
  assign rsp_o.way            = rsp_way_q;
  assign rsp_o.writeback      = rsp_wb_q;
  assign rsp_o.writeback_line = rsp_wb_line_q;
  assign rsp_o.fill           = rsp_fill_q;
  assign rsp_o.fill_line      = rsp_fill_line_q;

endmodule
